@@ hw/rtl/tas_pkg.sv @@
// Shared types and codes for the timed action sequencer.
package tas_pkg;

  localparam int unsigned DUR_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ENTRY_IDX_W = 4;
  localparam int unsigned ACT_IDX_W  = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_DONE        = 2'd1,
    ST_REFUSED     = 2'd2,
    ST_REFUSED_REP = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTION_COUNT = 1'd0,
    REG_CYCLE_LIMIT  = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic                 issued;
    logic [ACT_IDX_W-1:0] action_index;
    status_t              status;
    logic                 running;
  } result_t;

endpackage

@@ hw/rtl/tas_table.sv @@
// Action table: duration and repeat flag per slot, registered read with write bypass.
module tas_table import tas_pkg::*; #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DUR_W-1:0]  wr_dur,
  input  logic              wr_rep,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DUR_W-1:0]  rd_dur,
  output logic              rd_rep
);

  logic [DUR_W:0] mem [DEPTH];
  logic [DUR_W:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_rep, wr_dur};
    end
  end

  // A load to the slot being fetched must be seen by the next tick
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= {wr_rep, wr_dur};
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_dur = rd_data_r[DUR_W-1:0];
  assign rd_rep = rd_data_r[DUR_W];

endmodule

@@ hw/rtl/tas_core.sv @@
// Sequencer state and per-item decision logic.
module tas_core import tas_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned PASS_WIDTH = 16,
  parameter int unsigned PTR_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  mode_t                  mode,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic                   issue_ok,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [COUNT_W-1:0]     action_count,
  input  logic [LIMIT_W-1:0]     cycle_limit,
  input  logic [DUR_W-1:0]       tbl_dur,
  input  logic                   tbl_rep,
  output logic                   tbl_wr_en,
  output logic [PTR_W-1:0]       tbl_wr_addr,
  output logic [PTR_W-1:0]       tbl_rd_addr,
  output result_t                res
);

  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

  logic                  active_r, active_nxt;
  logic                  await_r, await_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [PASS_WIDTH-1:0] pass_r, pass_nxt;
  logic [TIME_W-1:0]     start_r, start_nxt;

  logic [CNT_W-1:0]      used_cnt;
  logic [TIME_W-1:0]     elapsed;
  logic [PTR_W:0]        next_ptr;
  logic [PASS_WIDTH-1:0] pass_inc;
  logic [PTR_W-1:0]      ptr_cand;
  logic                  finish;

  always_comb begin
    if (32'(action_count) > MAX_STEPS) begin
      used_cnt = CNT_W'(MAX_STEPS);
    end else begin
      used_cnt = CNT_W'(action_count);
    end
  end

  assign elapsed     = now_ms - start_r;
  assign next_ptr    = (PTR_W+1)'(ptr_r) + (PTR_W+1)'(1);
  assign pass_inc    = (pass_r == '1) ? pass_r : pass_r + PASS_WIDTH'(1);
  assign tbl_wr_addr = PTR_W'(entry_index);
  assign tbl_rd_addr = ptr_nxt;

  always_comb begin
    active_nxt       = active_r;
    await_nxt        = await_r;
    ptr_nxt          = ptr_r;
    pass_nxt         = pass_r;
    start_nxt        = start_r;
    tbl_wr_en        = 1'b0;
    ptr_cand         = next_ptr[PTR_W-1:0];
    finish           = 1'b0;
    res.issued       = 1'b0;
    res.status       = ST_OK;
    if (step) begin
      case (mode)
        MODE_LOAD: begin
          if (32'(entry_index) < MAX_STEPS) tbl_wr_en = 1'b1;
        end
        MODE_START: begin
          if (used_cnt != '0) begin
            active_nxt = 1'b1;
            await_nxt  = 1'b1;
          end
        end
        MODE_STOP: begin
          active_nxt = 1'b0;
        end
        MODE_TICK: begin
          if (active_r) begin
            if (await_r) begin
              await_nxt  = 1'b0;
              ptr_nxt    = '0;
              start_nxt  = now_ms;
              pass_nxt   = '0;
              res.issued = 1'b1;
              if (!issue_ok) begin
                active_nxt = 1'b0;
                res.status = ST_REFUSED;
              end
            end else if (elapsed >= tbl_dur) begin
              // end of table: count a pass, then finish or wrap
              if (32'(next_ptr) >= 32'(used_cnt)) begin
                pass_nxt = pass_inc;
                if ((cycle_limit != '0) && (32'(pass_inc) >= 32'(cycle_limit))) begin
                  finish = 1'b1;
                end else begin
                  ptr_cand = '0;
                end
              end
              if (finish) begin
                active_nxt = 1'b0;
                res.status = ST_DONE;
              end else begin
                ptr_nxt    = ptr_cand;
                start_nxt  = now_ms;
                res.issued = 1'b1;
                if (!issue_ok) begin
                  active_nxt = 1'b0;
                  res.status = ST_REFUSED;
                end
              end
            end else if (tbl_rep) begin
              res.issued = 1'b1;
              if (!issue_ok) res.status = ST_REFUSED_REP;
            end
          end
        end
        default: ;
      endcase
    end
    res.action_index = ACT_IDX_W'(ptr_nxt);
    res.running      = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      await_r  <= 1'b0;
      ptr_r    <= '0;
      pass_r   <= '0;
      start_r  <= '0;
    end else begin
      active_r <= active_nxt;
      await_r  <= await_nxt;
      ptr_r    <= ptr_nxt;
      pass_r   <= pass_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

@@ hw/rtl/timed_action_sequencer.sv @@
// Timed action sequencer: one item per clock while results are taken. Each input
// transfer lands in an input register; the sequencer state, the registered
// action-table fetch and the live configuration then decide the result, which is
// held in an output register. A new item is taken every cycle while results are
// taken; out_stall backs up through the two registers to in_stall. The table has
// MAX_STEPS slots, read through a register at the pointer the current item leaves,
// so ticks run back to back. The user writes configuration through cfg_wr_en/
// cfg_index/cfg_data (0 action_count, 1 cycle_limit) only while idle; the block does not enforce this.
module timed_action_sequencer import tas_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned PASS_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic [TIME_W-1:0]      in_now_ms,
  input  logic                   in_issue_ok,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [DUR_W-1:0]       in_entry_duration,
  input  logic                   in_entry_repeat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_issued,
  output logic [ACT_IDX_W-1:0]   out_action_index,
  output logic [1:0]             out_status,
  output logic                   out_running,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PTR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [COUNT_W-1:0]     action_count_r;
  logic [LIMIT_W-1:0]     cycle_limit_r;

  logic                   in_vld_r;
  mode_t                  mode_r;
  logic [TIME_W-1:0]      now_r;
  logic                   ok_r;
  logic [ENTRY_IDX_W-1:0] eidx_r;
  logic [DUR_W-1:0]       edur_r;
  logic                   erep_r;

  logic                   out_vld_r;
  result_t                res_r;
  result_t                res;

  logic                   adv;
  logic                   in_xfer;
  logic                   step;

  logic                   tbl_wr_en;
  logic [PTR_W-1:0]       tbl_wr_addr;
  logic [PTR_W-1:0]       tbl_rd_addr;
  logic [DUR_W-1:0]       tbl_dur;
  logic                   tbl_rep;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = in_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_count_r <= '0;
      cycle_limit_r  <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ACTION_COUNT: action_count_r <= cfg_data[COUNT_W-1:0];
        REG_CYCLE_LIMIT:  cycle_limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_t'(in_mode);
      now_r  <= in_now_ms;
      ok_r   <= in_issue_ok;
      eidx_r <= in_entry_index;
      edur_r <= in_entry_duration;
      erep_r <= in_entry_repeat;
    end
    if (step) res_r <= res;
  end

  tas_core #(
    .MAX_STEPS  (MAX_STEPS),
    .PASS_WIDTH (PASS_WIDTH),
    .PTR_W      (PTR_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .mode         (mode_r),
    .now_ms       (now_r),
    .issue_ok     (ok_r),
    .entry_index  (eidx_r),
    .action_count (action_count_r),
    .cycle_limit  (cycle_limit_r),
    .tbl_dur      (tbl_dur),
    .tbl_rep      (tbl_rep),
    .tbl_wr_en    (tbl_wr_en),
    .tbl_wr_addr  (tbl_wr_addr),
    .tbl_rd_addr  (tbl_rd_addr),
    .res          (res)
  );

  tas_table #(
    .DEPTH  (MAX_STEPS),
    .ADDR_W (PTR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_dur  (edur_r),
    .wr_rep  (erep_r),
    .rd_addr (tbl_rd_addr),
    .rd_dur  (tbl_dur),
    .rd_rep  (tbl_rep)
  );

  assign out_valid        = out_vld_r;
  assign out_issued       = res_r.issued;
  assign out_action_index = res_r.action_index;
  assign out_status       = res_r.status;
  assign out_running      = res_r.running;

endmodule

@@ verif/timed_action_sequencer_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the timed action sequencer, with its own step predictor.
module timed_action_sequencer_test;
  import tas_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam logic [15:0] PASS_CEIL = 16'hFFFF;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 245;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    mode_t       mode;
    logic [31:0] now;
    logic        ok;
    logic [3:0]  idx;
    logic [31:0] dur;
    logic        rep;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_TICK;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic in_issue_ok = 1'b0;
  logic [ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic [DUR_W-1:0] in_entry_duration = '0;
  logic in_entry_repeat = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_issued;
  logic [ACT_IDX_W-1:0] out_action_index;
  logic [1:0] out_status;
  logic out_running;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACTION_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  timed_action_sequencer DUT (.*);

  always #1 clk = ~clk;

  // predictor state and its copy of the configuration
  logic [31:0] dur_tab [TABLE_SLOTS];
  logic        rep_tab [TABLE_SLOTS];
  logic        seq_active = 1'b0;
  logic        seq_armed = 1'b0;
  logic [3:0]  cur_step = '0;
  logic [15:0] pass_tally = '0;
  logic [31:0] step_began_ms = '0;
  logic [4:0]  count_reg = '0;
  logic [15:0] limit_reg = '0;

  cmd_t    cmd_queue [$];
  result_t awaited_results [$];
  cmd_t    drv_cmd;
  result_t want;
  result_t got_pred;
  bit      in_taken = 1'b0;
  int      idle_mode = IDLE_NONE;
  int      queued_total = 0;
  int      accepted_total = 0;
  int      err_count = 0;
  int      cycle_count = 0;
  logic [31:0] sim_ms = '0;

  int unsigned phase_counts [PHASES] = '{16, 0, 1, 5, 16, 3, 8, 2};
  int unsigned phase_limits [PHASES] = '{2, 0, 1, 0, 65535, 3, 1, 0};

  task automatic advance_sequence(input cmd_t c, output result_t r);
    int steps_used;
    int nxt;
    logic [31:0] elapsed;
    logic issue;
    status_t st;
    issue = 1'b0;
    st = ST_OK;
    steps_used = (count_reg > TABLE_SLOTS) ? TABLE_SLOTS : count_reg;
    case (c.mode)
      MODE_LOAD: begin
        dur_tab[c.idx] = c.dur;
        rep_tab[c.idx] = c.rep;
      end
      MODE_START: begin
        if (steps_used > 0) begin
          seq_active = 1'b1;
          seq_armed = 1'b1;
        end
      end
      MODE_STOP: begin
        seq_active = 1'b0;
      end
      default: begin
        if (seq_active && seq_armed) begin
          seq_armed = 1'b0;
          cur_step = '0;
          step_began_ms = c.now;
          pass_tally = '0;
          issue = 1'b1;
          if (!c.ok) begin
            seq_active = 1'b0;
            st = ST_REFUSED;
          end
        end else if (seq_active) begin
          elapsed = c.now - step_began_ms;
          if (elapsed >= dur_tab[cur_step]) begin
            nxt = cur_step + 1;
            if (nxt >= steps_used) begin
              if (pass_tally != PASS_CEIL) pass_tally++;
              nxt = 0;
              // pass limit reached: pointer stays on the last action
              if (limit_reg != 0 && pass_tally >= limit_reg) begin
                seq_active = 1'b0;
                st = ST_DONE;
              end
            end
            if (st != ST_DONE) begin
              cur_step = nxt[3:0];
              step_began_ms = c.now;
              issue = 1'b1;
              if (!c.ok) begin
                seq_active = 1'b0;
                st = ST_REFUSED;
              end
            end
          end else if (rep_tab[cur_step]) begin
            issue = 1'b1;
            st = c.ok ? ST_OK : ST_REFUSED_REP;
          end
        end
      end
    endcase
    r.issued = issue;
    r.action_index = cur_step;
    r.status = st;
    r.running = seq_active;
  endtask

  function automatic cmd_t make_cmd(mode_t m, logic [31:0] now, logic ok,
                                    logic [3:0] idx, logic [31:0] dur, logic rep);
    cmd_t c;
    c.mode = m;
    c.now = now;
    c.ok = ok;
    c.idx = idx;
    c.dur = dur;
    c.rep = rep;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c = make_cmd(MODE_TICK, $urandom(), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), $urandom(), 1'($urandom_range(0, 1)));
    if (pick < 2) begin
      c.mode = MODE_START;
    end else if (pick < 4) begin
      c.mode = MODE_STOP;
    end else if (pick < 12) begin
      c.mode = MODE_LOAD;
      // mostly short actions so runs move; now and then a huge one
      if ($urandom_range(0, 14) != 0) c.dur = $urandom_range(0, 10);
      c.rep = ($urandom_range(0, 2) == 0);
    end else begin
      if ($urandom_range(0, 32) == 0) sim_ms = $urandom();
      else sim_ms = sim_ms + $urandom_range(0, 6);
      c.now = sim_ms;
      c.ok = ($urandom_range(0, 19) != 0);
    end
    return c;
  endfunction

  task automatic queue_cmd(input cmd_t c);
    cmd_queue.push_back(c);
    queued_total++;
  endtask

  task automatic queue_directed();
    logic [31:0] d;
    // fill every slot first so no run ever reads an unloaded one
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      d = (i % 3) + 1;
      if (i == 2) d = '0;
      if (i == TABLE_SLOTS - 1) d = 32'hFFFF_FFFF;
      queue_cmd(make_cmd(MODE_LOAD, 32'hFFFF_FFFF, 1'b1, 4'(i), d, i[0] | (i == 15)));
    end
    queue_cmd(make_cmd(MODE_TICK, 32'h0, 1'b1, 4'hF, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_START, 32'h0, 1'b0, 4'h0, 32'hFFFF_FFFF, 1'b1));
    queue_cmd(make_cmd(MODE_TICK, 32'hFFFF_FFFE, 1'b0, 4'h0, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_START, 32'h0, 1'b1, 4'h0, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_TICK, 32'hFFFF_FFFF, 1'b1, 4'h0, 32'h0, 1'b0));
    // elapsed time wraps through zero here
    queue_cmd(make_cmd(MODE_TICK, 32'h0, 1'b1, 4'h0, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_TICK, 32'h0, 1'b0, 4'h0, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_TICK, 32'h5, 1'b0, 4'h0, 32'h0, 1'b0));
    queue_cmd(make_cmd(MODE_STOP, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF, 1'b1));
    sim_ms = 32'h5;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_ACTION_COUNT) count_reg = val[4:0];
    else limit_reg = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic bit roll_idle(int who);
    int pct;
    pct = 0;
    if (idle_mode == IDLE_BOTH) pct = 31;
    else if (idle_mode == who) pct = 82;
    return $urandom_range(0, 99) < pct;
  endfunction

  // driver: next item and receiver stall change on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (cmd_queue.size() != 0 && !roll_idle(IDLE_SENDER)) begin
          drv_cmd = cmd_queue.pop_front();
          in_mode <= drv_cmd.mode;
          in_now_ms <= drv_cmd.now;
          in_issue_ok <= drv_cmd.ok;
          in_entry_index <= drv_cmd.idx;
          in_entry_duration <= drv_cmd.dur;
          in_entry_repeat <= drv_cmd.rep;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= roll_idle(IDLE_RECEIVER);
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_sequence(drv_cmd, got_pred);
        awaited_results.push_back(got_pred);
        accepted_total++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited");
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_issued !== want.issued) begin
            $error("issued: expected %0d, got %0d", want.issued, out_issued);
            err_count++;
          end
          if (out_action_index !== want.action_index) begin
            $error("action_index: expected %0d, got %0d", want.action_index,
                   out_action_index);
            err_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_count++;
          end
          if (out_running !== want.running) begin
            $error("running: expected %0d, got %0d", want.running, out_running);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed_action_sequencer test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      dur_tab[i] = '0;
      rep_tab[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = ph % 4;
      // the run is left active across phases, so count changes land mid-run
      write_reg(REG_ACTION_COUNT, CFG_DATA_W'(phase_counts[ph]));
      write_reg(REG_CYCLE_LIMIT, CFG_DATA_W'(phase_limits[ph]));
      if (ph == 0) queue_directed();
      repeat (RANDOM_PER_PHASE) queue_cmd(random_cmd());
      while (accepted_total != queued_total || awaited_results.size() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("timed_action_sequencer test passed");
    end else begin
      $display("timed_action_sequencer test failed");
    end
    $finish;
  end

endmodule
